// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH = 256;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_BACK  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_BACK   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// source of the new end word once the operation completes
	typedef enum logic [1:0] {
		SEL_KEEP,
		SEL_VALUE,
		SEL_MEM
	} sel_t;

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} state_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_LAST) ? '0 : IDX_W'(i + 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_LAST : IDX_W'(i - 1'b1);
	endfunction

endpackage

// ===== hdl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words held in a single-port-read ring RAM.
// ----------------------------------------------------------------------------
// Each word on the input is one operation (push front, push back, pop front,
// pop back) and yields exactly one result word. The accept cycle updates the
// ring indexes and the count and issues the RAM write or the read of the
// entry next to the removed one; once the output register is free or taken,
// the pushed value or RAM data goes to the end word registers and the output
// register is loaded. A new operation is taken only when idle, after the last
// one has finished. The output register lets the next operation enter while
// a result still waits. Pop on an empty queue returns status 1 and push on a
// full queue returns status 2; neither changes the contents. Reset sets only
// the indexes, count, state and output valid flag; the RAM is not cleared,
// and only entries that hold a queued word are ever reported.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         kind,
	input  logic signed [deq_pkg::DATA_W-1:0]  push_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [deq_pkg::DATA_W-1:0]  popped_value,
	output logic [1:0]                         status,
	output logic [deq_pkg::CNT_W-1:0]          entries_now,
	output logic signed [deq_pkg::DATA_W-1:0]  front_value,
	output logic signed [deq_pkg::DATA_W-1:0]  back_value,
	output logic                               has_items
);

	logic [deq_pkg::DATA_W-1:0] ring_mem [deq_pkg::DEPTH];
	logic [deq_pkg::DATA_W-1:0] rd_data_q;

	deq_pkg::state_t state_q, state_d;
	logic accept, finish;

	// ring indexes; back index is front + count - 1 modulo the depth
	logic [deq_pkg::IDX_W-1:0] front_idx_q, back_idx_q, front_idx_d, back_idx_d;
	logic [deq_pkg::CNT_W-1:0] count_q, count_d;

	// words currently at the two ends
	logic [deq_pkg::DATA_W-1:0] front_val_q, back_val_q, front_new, back_new;

	// operation in flight
	deq_pkg::status_t op_status_q, op_status_d;
	logic [deq_pkg::DATA_W-1:0] op_popped_q, op_popped_d, op_value_q;
	deq_pkg::sel_t fsel_q, fsel_d, bsel_q, bsel_d;

	logic wr_en, rd_en;
	logic [deq_pkg::IDX_W-1:0] wr_addr, rd_addr;

	logic out_valid_q;
	logic [deq_pkg::DATA_W-1:0] popped_q, front_out_q, back_out_q;
	logic [1:0] status_q;
	logic [deq_pkg::CNT_W-1:0] entries_q;
	logic has_items_q;

	logic is_empty, is_full;

	// ---- control ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deq_pkg::S_IDLE: if (in_valid) state_d = deq_pkg::S_BUSY;
			deq_pkg::S_BUSY: if (!out_valid_q || out_ready) state_d = deq_pkg::S_IDLE;
			default: state_d = deq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			deq_pkg::S_IDLE: in_ready = 1'b1;
			deq_pkg::S_BUSY: finish = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- decode the operation ----
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == deq_pkg::CNT_FULL);

	always_comb begin
		front_idx_d = front_idx_q;
		back_idx_d  = back_idx_q;
		count_d     = count_q;
		op_status_d = deq_pkg::STATUS_OK;
		op_popped_d = '0;
		fsel_d      = deq_pkg::SEL_KEEP;
		bsel_d      = deq_pkg::SEL_KEEP;
		wr_en       = 1'b0;
		wr_addr     = deq_pkg::idx_dec(front_idx_q);
		rd_en       = 1'b0;
		rd_addr     = deq_pkg::idx_inc(front_idx_q);
		case (deq_pkg::kind_t'(kind))
			deq_pkg::KIND_PUSH_FRONT: begin
				if (is_full) begin
					op_status_d = deq_pkg::STATUS_FULL;
				end else begin
					wr_en       = 1'b1;
					wr_addr     = deq_pkg::idx_dec(front_idx_q);
					front_idx_d = wr_addr;
					count_d     = deq_pkg::CNT_W'(count_q + 1'b1);
					fsel_d      = deq_pkg::SEL_VALUE;
					bsel_d      = is_empty ? deq_pkg::SEL_VALUE : deq_pkg::SEL_KEEP;
				end
			end
			deq_pkg::KIND_PUSH_BACK: begin
				if (is_full) begin
					op_status_d = deq_pkg::STATUS_FULL;
				end else begin
					wr_en      = 1'b1;
					wr_addr    = deq_pkg::idx_inc(back_idx_q);
					back_idx_d = wr_addr;
					count_d    = deq_pkg::CNT_W'(count_q + 1'b1);
					bsel_d     = deq_pkg::SEL_VALUE;
					fsel_d     = is_empty ? deq_pkg::SEL_VALUE : deq_pkg::SEL_KEEP;
				end
			end
			deq_pkg::KIND_POP_FRONT: begin
				if (is_empty) begin
					op_status_d = deq_pkg::STATUS_EMPTY;
				end else begin
					op_popped_d = front_val_q;
					// fetch the word behind the front; unused when this empties the queue
					rd_en       = 1'b1;
					rd_addr     = deq_pkg::idx_inc(front_idx_q);
					front_idx_d = rd_addr;
					count_d     = deq_pkg::CNT_W'(count_q - 1'b1);
					fsel_d      = deq_pkg::SEL_MEM;
				end
			end
			default: begin
				if (is_empty) begin
					op_status_d = deq_pkg::STATUS_EMPTY;
				end else begin
					op_popped_d = back_val_q;
					rd_en       = 1'b1;
					rd_addr     = deq_pkg::idx_dec(back_idx_q);
					back_idx_d  = rd_addr;
					count_d     = deq_pkg::CNT_W'(count_q - 1'b1);
					bsel_d      = deq_pkg::SEL_MEM;
				end
			end
		endcase
	end

	// ---- ring memory ----
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			ring_mem[wr_addr] <= push_value;
		end
		if (accept && rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_idx_q <= '0;
			back_idx_q  <= deq_pkg::IDX_LAST;
			count_q     <= '0;
		end else if (accept) begin
			front_idx_q <= front_idx_d;
			back_idx_q  <= back_idx_d;
			count_q     <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_status_q <= op_status_d;
			op_popped_q <= op_popped_d;
			op_value_q  <= push_value;
			fsel_q      <= fsel_d;
			bsel_q      <= bsel_d;
		end
	end

	// ---- complete: new end words and the result ----
	always_comb begin
		case (fsel_q)
			deq_pkg::SEL_VALUE: front_new = op_value_q;
			deq_pkg::SEL_MEM:   front_new = rd_data_q;
			default:            front_new = front_val_q;
		endcase
		case (bsel_q)
			deq_pkg::SEL_VALUE: back_new = op_value_q;
			deq_pkg::SEL_MEM:   back_new = rd_data_q;
			default:            back_new = back_val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			front_val_q <= front_new;
			back_val_q  <= back_new;
			popped_q    <= op_popped_q;
			status_q    <= op_status_q;
			entries_q   <= count_q;
			has_items_q <= (count_q != '0);
			front_out_q <= (count_q != '0) ? front_new : '0;
			back_out_q  <= (count_q != '0) ? back_new : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign status       = status_q;
	assign entries_now  = entries_q;
	assign front_value  = front_out_q;
	assign back_value   = back_out_q;
	assign has_items    = has_items_q;

endmodule

// ===== hdl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue results, bound to the top.
// ----------------------------------------------------------------------------
module deq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [1:0]                         kind,
	input logic signed [deq_pkg::DATA_W-1:0]  push_value,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [deq_pkg::DATA_W-1:0]  popped_value,
	input logic [1:0]                         status,
	input logic [deq_pkg::CNT_W-1:0]          entries_now,
	input logic signed [deq_pkg::DATA_W-1:0]  front_value,
	input logic signed [deq_pkg::DATA_W-1:0]  back_value,
	input logic                               has_items
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(popped_value)
			&& $stable(status) && $stable(entries_now))
		else $error("result changed while stalled");

	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (has_items == (entries_now != '0))
			&& (entries_now <= deq_pkg::CNT_FULL))
		else $error("has_items disagrees with entries_now");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == deq_pkg::STATUS_EMPTY || status == deq_pkg::STATUS_FULL)
			|-> popped_value == '0)
		else $error("error result carries a popped word");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_items |-> front_value == '0 && back_value == '0)
		else $error("empty queue reports end words");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == deq_pkg::STATUS_OK || status == deq_pkg::STATUS_EMPTY
			|| status == deq_pkg::STATUS_FULL)
		else $error("undefined status code");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
